// ===== hdl/sdx_pkg.sv =====
`default_nettype none
package sdx_pkg;

  localparam int CODE_DIGITS_DEF = 3;
  localparam int DIGIT_W         = 3;
  localparam int CHAR_W          = 8;
  localparam int OUT_DIGITS      = 3;

  localparam logic [CHAR_W-1:0] CH_W = 8'h77;
  localparam logic [CHAR_W-1:0] CH_H = 8'h68;
  localparam logic [CHAR_W-1:0] CH_Y = 8'h79;
  localparam logic [CHAR_W-1:0] CH_A_UP = 8'h41;
  localparam logic [CHAR_W-1:0] CH_Z_UP = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_A_LO = 8'h61;
  localparam logic [CHAR_W-1:0] CH_Z_LO = 8'h7a;
  localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;

  typedef struct packed {
    logic                                code_valid;
    logic [CHAR_W-1:0]                   first_letter;
    logic [OUT_DIGITS-1:0][DIGIT_W-1:0]  digits;
  } res_t;

  function automatic logic [DIGIT_W-1:0] letter_code(input logic [CHAR_W-1:0] c);
    logic [DIGIT_W-1:0] code;
    unique case (c)
      8'h62, 8'h66, 8'h70, 8'h76:                       code = 3'd1;
      8'h63, 8'h67, 8'h6a, 8'h6b,
      8'h71, 8'h73, 8'h78, 8'h7a:                       code = 3'd2;
      8'h64, 8'h74:                                     code = 3'd3;
      8'h6c:                                            code = 3'd4;
      8'h6d, 8'h6e:                                     code = 3'd5;
      8'h72:                                            code = 3'd6;
      default:                                          code = 3'd0;
    endcase
    return code;
  endfunction

  function automatic logic is_why(input logic [CHAR_W-1:0] c);
    return (c == CH_W) || (c == CH_H) || (c == CH_Y);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/soundex_encoder.sv =====
// A word's code is registered on out_ once its last byte is accepted, via the skid stage if out_ is stalled.
// Throughput: one byte per cycle while the skid stage is empty; state and code
// logic sit between the letter registers and a result register backed by one skid stage.
// Reset (rst_n low at a clock edge, synchronous) clears the word state and the
// valid flags of both result stages; in_ready is high from the first reset edge on.
`default_nettype none
module soundex_encoder #(
  parameter int CODE_DIGITS = sdx_pkg::CODE_DIGITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic [7:0] in_char_byte,
  input  wire logic       in_last_char,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      logic       out_code_valid,
  output      logic [7:0] out_first_letter,
  output      logic [2:0] out_digit_one,
  output      logic [2:0] out_digit_two,
  output      logic [2:0] out_digit_three
);
  import sdx_pkg::*;

  localparam int TALLY_W = $clog2(CODE_DIGITS + 1);

  logic [CHAR_W-1:0]  lead_r, lead_nxt;
  logic [CHAR_W-1:0]  kb1_r, kb1_nxt;
  logic [CHAR_W-1:0]  kb2_r, kb2_nxt;
  logic [1:0]         kept_tally_r, kept_tally_nxt;
  logic [DIGIT_W-1:0] digits_r   [CODE_DIGITS];
  logic [DIGIT_W-1:0] digits_nxt [CODE_DIGITS];
  logic [TALLY_W-1:0] digit_tally_r, digit_tally_nxt;
  logic               bad_r, bad_nxt;

  res_t res_r, res_nxt;
  res_t skid_r, skid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;

  logic               accept;
  logic               is_letter;
  logic [CHAR_W-1:0]  letter;
  logic [DIGIT_W-1:0] code;
  logic [DIGIT_W-1:0] prev_code;
  logic               drop;
  logic               bridged;
  logic               keep;
  res_t               word_res;
  logic [DIGIT_W-1:0] res_dig [OUT_DIGITS];

  assign in_ready = !skid_valid_r;
  assign accept   = in_valid && in_ready;

  assign letter    = in_char_byte | CASE_BIT;
  assign is_letter = ((in_char_byte >= CH_A_UP) && (in_char_byte <= CH_Z_UP)) ||
                     ((in_char_byte >= CH_A_LO) && (in_char_byte <= CH_Z_LO));
  assign code      = letter_code(letter);
  assign prev_code = letter_code(kb1_r);
  assign drop      = ((code != '0) && (prev_code != '0)) ? (code == prev_code)
                                                         : ((letter == kb1_r) && !is_why(letter));
  assign bridged   = (kept_tally_r == 2'd2) && (letter_code(kb2_r) == code) && is_why(kb1_r);
  assign keep      = (kept_tally_r == 2'd0) || !drop;

  always_comb begin
    lead_nxt        = lead_r;
    kb1_nxt         = kb1_r;
    kb2_nxt         = kb2_r;
    kept_tally_nxt  = kept_tally_r;
    digits_nxt      = digits_r;
    digit_tally_nxt = digit_tally_r;
    bad_nxt         = bad_r;
    if (is_letter) begin
      if (kept_tally_r == 2'd0) begin
        lead_nxt = letter;
      end
      if (keep) begin
        kb2_nxt = kb1_r;
        kb1_nxt = letter;
        if (kept_tally_r != 2'd2) begin
          kept_tally_nxt = kept_tally_r + 2'd1;
        end
        if ((kept_tally_r != 2'd0) && (code != '0) && !bridged &&
            (digit_tally_r < TALLY_W'(CODE_DIGITS))) begin
          for (int i = 0; i < CODE_DIGITS; i++) begin
            if (digit_tally_r == TALLY_W'(i)) begin
              digits_nxt[i] = code;
            end
          end
          digit_tally_nxt = digit_tally_r + TALLY_W'(1);
        end
      end
    end else begin
      bad_nxt = 1'b1;
    end
  end

  for (genvar k = 0; k < OUT_DIGITS; k++) begin : g_dig
    if (k < CODE_DIGITS) begin : g_have
      assign res_dig[k] = digits_nxt[k];
    end else begin : g_pad
      assign res_dig[k] = '0;
    end
  end

  always_comb begin
    word_res = '0;
    if (!bad_nxt) begin
      word_res.code_valid   = 1'b1;
      word_res.first_letter = lead_nxt;
      for (int k = 0; k < OUT_DIGITS; k++) begin
        word_res.digits[k] = res_dig[k];
      end
    end
  end

  // output register with one skid stage
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    res_nxt        = res_r;
    skid_nxt       = skid_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        res_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        res_nxt       = word_res;
        out_valid_nxt = accept && in_last_char;
      end
    end else if (accept && in_last_char) begin
      skid_nxt       = word_res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r        <= '0;
      kb1_r         <= '0;
      kb2_r         <= '0;
      kept_tally_r  <= '0;
      digit_tally_r <= '0;
      bad_r         <= 1'b0;
      for (int i = 0; i < CODE_DIGITS; i++) begin
        digits_r[i] <= '0;
      end
    end else if (accept) begin
      if (in_last_char) begin
        lead_r        <= '0;
        kb1_r         <= '0;
        kb2_r         <= '0;
        kept_tally_r  <= '0;
        digit_tally_r <= '0;
        bad_r         <= 1'b0;
        for (int i = 0; i < CODE_DIGITS; i++) begin
          digits_r[i] <= '0;
        end
      end else begin
        lead_r        <= lead_nxt;
        kb1_r         <= kb1_nxt;
        kb2_r         <= kb2_nxt;
        kept_tally_r  <= kept_tally_nxt;
        digit_tally_r <= digit_tally_nxt;
        bad_r         <= bad_nxt;
        digits_r      <= digits_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_code_valid   = res_r.code_valid;
  assign out_first_letter = res_r.first_letter;
  assign out_digit_one    = res_r.digits[0];
  assign out_digit_two    = res_r.digits[1];
  assign out_digit_three  = res_r.digits[2];

endmodule
`default_nettype wire

// ===== hdl/sdx_checker.sv =====
`default_nettype none
module sdx_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_code_valid,
  input wire logic [7:0] out_first_letter,
  input wire logic [2:0] out_digit_one,
  input wire logic [2:0] out_digit_two,
  input wire logic [2:0] out_digit_three
);
  import sdx_pkg::*;

  // stalled request holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code_valid) &&
      $stable(out_first_letter) && $stable(out_digit_one) &&
      $stable(out_digit_two) && $stable(out_digit_three))
    else $error("result request changed while stalled");

  a_bad_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_code_valid |-> out_first_letter == '0 &&
      out_digit_one == '0 && out_digit_two == '0 && out_digit_three == '0)
    else $error("invalid word carries non-zero fields");

  a_lead_lower: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_code_valid |-> out_first_letter >= CH_A_LO && out_first_letter <= CH_Z_LO)
    else $error("first letter not lower case");

  a_pad_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_digit_one == '0 || out_digit_two == '0) |-> out_digit_three == '0 &&
      (out_digit_one != '0 || out_digit_two == '0))
    else $error("padding digit before a code digit");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_digit_one <= 3'd6 && out_digit_two <= 3'd6 && out_digit_three <= 3'd6)
    else $error("digit out of range");

endmodule

bind soundex_encoder sdx_checker u_sdx_checker (.*);
`default_nettype wire
